>>> design/ugmc_pkg.sv
// Shared types and constants for the update gap miss counter.
// Used by ugmc_divider and update_gap_miss_counter_core; depends on nothing.
package ugmc_pkg;

   localparam int DATA_W = 32;
   localparam int CNT_W  = $clog2(DATA_W);

   typedef logic [DATA_W-1:0] data_type;

   // input item kinds
   typedef enum logic [1:0] {
      MODE_START  = 2'd0,
      MODE_UPDATE = 2'd1,
      MODE_END    = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   // result event kinds
   typedef enum logic [2:0] {
      EV_ENTERED   = 3'd0,
      EV_INVALID   = 3'd1,
      EV_FIRST     = 3'd2,
      EV_VALID     = 3'd3,
      EV_END_VALID = 3'd4,
      EV_EMPTY_END = 3'd5
   } kind_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_INTERVAL  = 2'd0,
      CSR_TOLERANCE = 2'd1,
      CSR_MIN_GAP   = 2'd2,
      CSR_MAX_GAP   = 2'd3
   } csr_type;

   localparam data_type INTERVAL_RESET = 32'd1000;
   localparam data_type ALL_ONES       = {DATA_W{1'b1}};

   // divider request and status
   typedef struct packed {
      logic     start;
      data_type dividend;
      data_type divisor;
   } div_req_type;

   typedef struct packed {
      logic     busy;
      logic     done;
      data_type quotient;
   } div_rsp_type;

endpackage

>>> design/ugmc_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on ugmc_pkg for widths and the request/status structs.
module ugmc_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  ugmc_pkg::div_req_type div_req,
   output ugmc_pkg::div_rsp_type div_rsp
);
   import ugmc_pkg::*;

   data_type          rem_ff, rem_in;
   data_type          num_ff, num_in;
   data_type          den_ff, den_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DATA_W:0]   trial;
   logic [DATA_W:0]   diff;
   logic              qbit;

   // one shift-subtract step
   always_comb begin
      trial = {rem_ff, num_ff[DATA_W-1]};
      diff  = trial - {1'b0, den_ff};
      qbit  = (trial >= {1'b0, den_ff});

      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (div_req.start && !busy_ff) begin
         rem_in  = '0;
         num_in  = div_req.dividend;
         den_in  = div_req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = qbit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
         num_in = {num_ff[DATA_W-2:0], qbit};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = num_ff;

endmodule

>>> design/update_gap_miss_counter_core.sv
// Update gap miss counter: event sequencer, gap checks, totals and output register.
// Depends on ugmc_pkg and instantiates ugmc_divider.
//
// Usage:
//   req channel: tdata = timestamp_ms; tuser = mode (bits 1:0), update_valid (bit 2).
//   rsp channel: one transaction per item (mode three gives none); tdata = gap_ms,
//   misses, miss_sum from bit 0 up; tuser = event_kind.
//   csr port: csr_we writes csr_wdata into register csr_addr (interval, tolerance,
//   min gap, max gap) at the clock edge; write only while the block is idle.
// Sequencing:
//   a period start, an empty end or an invalid update goes from S_GAP straight to
//   S_DONE, which loads the output register; a checked gap passes S_RED and S_CHK,
//   and one that needs a division waits in S_DIV for the bit-serial divider (32 steps).
//   One item is in flight at a time; the next is accepted in the cycle after the
//   previous one has moved into the output register.
// Reset: synchronous; registers return to interval 1000, tolerance 0, min gap 0,
//   max gap all ones; period state and running total clear.
// Stall: a result waits in the output register while rsp_tready is low; the next
//   item is accepted and worked on, and holds before the output until it frees.
module update_gap_miss_counter_core #(
   parameter int TIME_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request: timestamp_ms
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // request: mode, update_valid
   input  logic [2:0]  req_tuser,
   // result: gap_ms, misses, miss_sum
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,
   // result: event_kind
   output logic [2:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata
);
   import ugmc_pkg::*;

   localparam int TW = (TIME_BITS < DATA_W) ? TIME_BITS : DATA_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_GAP,
      S_RED,
      S_CHK,
      S_DIV,
      S_DONE
   } state_type;

   state_type      state_ff, state_in;

   // configuration
   data_type       interval_ff, interval_in;
   data_type       tol_ff, tol_in;
   data_type       min_ff, min_in;
   data_type       max_ff, max_in;

   // period state
   logic [TW-1:0]  last_ff, last_in;
   logic           seen_ff, seen_in;
   data_type       total_ff, total_in;

   // item in work
   mode_type       mode_ff, mode_in;
   logic [TW-1:0]  ts_ff, ts_in;
   logic           upd_valid_ff, upd_valid_in;
   logic [TW-1:0]  gap_ff, gap_in;
   logic           under_ff, under_in;
   data_type       dred_ff, dred_in;
   data_type       miss_ff, miss_in;

   // output register
   logic           rsp_valid_ff, rsp_valid_in;
   kind_type       rsp_kind_ff, rsp_kind_in;
   data_type       rsp_gap_ff, rsp_gap_in;
   data_type       rsp_miss_ff, rsp_miss_in;
   data_type       rsp_total_ff, rsp_total_in;

   div_req_type    div_req;
   div_rsp_type    div_rsp;

   data_type       gap32;
   logic           zero_miss;
   logic           out_free;
   logic [DATA_W:0] sum;
   kind_type       kind;

   ugmc_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign gap32      = DATA_W'(gap_ff);
   assign sum        = {1'b0, total_ff} + {1'b0, miss_ff};

   // range and interval checks on the reduced gap
   assign zero_miss = under_ff
                   || ((min_ff != '0) && (dred_ff < min_ff))
                   || ((max_ff != ALL_ONES) && (dred_ff > max_ff))
                   || (interval_ff == '0)
                   || (dred_ff <= interval_ff);

   // event kind from the item and the period state before this item
   always_comb begin
      case (mode_ff)
         MODE_START:  kind = EV_ENTERED;
         MODE_UPDATE: kind = !upd_valid_ff ? EV_INVALID : (seen_ff ? EV_VALID : EV_FIRST);
         default:     kind = seen_ff ? EV_END_VALID : EV_EMPTY_END;
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      interval_in  = interval_ff;
      tol_in       = tol_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      last_in      = last_ff;
      seen_in      = seen_ff;
      total_in     = total_ff;
      mode_in      = mode_ff;
      ts_in        = ts_ff;
      upd_valid_in = upd_valid_ff;
      gap_in       = gap_ff;
      under_in     = under_ff;
      dred_in      = dred_ff;
      miss_in      = miss_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_gap_in   = rsp_gap_ff;
      rsp_miss_in  = rsp_miss_ff;
      rsp_total_in = rsp_total_ff;
      div_req.start    = 1'b0;
      div_req.dividend = dred_ff;
      div_req.divisor  = interval_ff;

      // register writes
      if (csr_we) begin
         unique case (csr_type'(csr_addr))
            CSR_INTERVAL:  interval_in = csr_wdata;
            CSR_TOLERANCE: tol_in      = csr_wdata;
            CSR_MIN_GAP:   min_in      = csr_wdata;
            CSR_MAX_GAP:   max_in      = csr_wdata;
            default:       ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               mode_in      = mode_type'(req_tuser[1:0]);
               upd_valid_in = req_tuser[2];
               ts_in        = req_tdata[TW-1:0];
               state_in     = S_GAP;
            end
         end
         // raw gap; period starts, empty ends and invalid updates skip the checks
         S_GAP: begin
            gap_in  = (ts_ff >= last_ff) ? (ts_ff - last_ff) : '0;
            miss_in = '0;
            case (mode_ff)
               MODE_START: begin
                  gap_in   = '0;
                  state_in = S_DONE;
               end
               MODE_UPDATE: begin
                  if (!upd_valid_ff) begin
                     gap_in   = '0;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_RED;
                  end
               end
               MODE_END: state_in = seen_ff ? S_RED : S_DONE;
               default:  state_in = S_IDLE;
            endcase
         end
         // take the tolerance off
         S_RED: begin
            under_in = (gap32 < tol_ff);
            dred_in  = gap32 - tol_ff;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (zero_miss) begin
               state_in = S_DONE;
            end else begin
               div_req.start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               miss_in  = div_rsp.quotient;
               state_in = S_DONE;
            end
         end
         // commit state and load the output register
         S_DONE: begin
            if (out_free) begin
               total_in     = sum[DATA_W] ? ALL_ONES : sum[DATA_W-1:0];
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind;
               rsp_gap_in   = gap32;
               rsp_miss_in  = miss_ff;
               rsp_total_in = total_in;
               case (mode_ff)
                  MODE_START: begin
                     last_in = ts_ff;
                     seen_in = 1'b0;
                  end
                  MODE_UPDATE: begin
                     if (upd_valid_ff) begin
                        last_in = ts_ff;
                        seen_in = 1'b1;
                     end
                  end
                  default: seen_in = 1'b0;
               endcase
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         interval_ff  <= INTERVAL_RESET;
         tol_ff       <= '0;
         min_ff       <= '0;
         max_ff       <= ALL_ONES;
         last_ff      <= '0;
         seen_ff      <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         interval_ff  <= interval_in;
         tol_ff       <= tol_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         last_ff      <= last_in;
         seen_ff      <= seen_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff      <= mode_in;
      ts_ff        <= ts_in;
      upd_valid_ff <= upd_valid_in;
      gap_ff       <= gap_in;
      under_ff     <= under_in;
      dred_ff      <= dred_in;
      miss_ff      <= miss_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_gap_ff   <= rsp_gap_in;
      rsp_miss_ff  <= rsp_miss_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_total_ff, rsp_miss_ff, rsp_gap_ff};
   assign rsp_tuser  = rsp_kind_ff;

`ifndef SYNTHESIS
   // running total only grows
   a_total_monotonic: assert property (@(posedge clock) disable iff (reset)
      total_ff >= $past(total_ff))
      else $error("running miss total decreased");

   // period starts and invalid updates carry no gap and no misses
   a_no_gap_events: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_kind_ff == EV_ENTERED || rsp_kind_ff == EV_INVALID)
      |-> (rsp_gap_ff == '0) && (rsp_miss_ff == '0))
      else $error("boundary or invalid update reported a gap");

   // an empty period counts no misses
   a_empty_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_kind_ff == EV_EMPTY_END) |-> (rsp_miss_ff == '0))
      else $error("empty period reported misses");

   // the divider only finishes while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide state");
`endif

endmodule

>>> tb/tb_update_gap_miss_counter_core.sv
// Self-checking testbench for update_gap_miss_counter_core: directed and random periods
// are checked against a transaction-level predictor held in a small scoreboard class.
// Depends on ugmc_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_update_gap_miss_counter_core;
   import ugmc_pkg::*;

   localparam int DRAIN_CYCLES = 60;
   localparam int PHASE_ITEMS  = 56;

   // one expected result transaction
   typedef struct {
      kind_type kind;
      data_type gap;
      data_type misses;
      data_type total;
   } gap_event_type;

   // predictor of the period/gap state plus the queue of expected result transactions
   class gap_miss_scoreboard_type;
      data_type      interval;
      data_type      tolerance;
      data_type      min_gap;
      data_type      max_gap;
      data_type      last_time;
      bit            valid_seen;
      data_type      running_total;
      gap_event_type expected_events[$];
      int            errors;

      function new();
         interval      = INTERVAL_RESET;
         tolerance     = '0;
         min_gap       = '0;
         max_gap       = ALL_ONES;
         last_time     = '0;
         valid_seen    = 1'b0;
         running_total = '0;
         errors        = 0;
      endfunction

      function void set_register(csr_type idx, data_type value);
         case (idx)
            CSR_INTERVAL:  interval  = value;
            CSR_TOLERANCE: tolerance = value;
            CSR_MIN_GAP:   min_gap   = value;
            CSR_MAX_GAP:   max_gap   = value;
         endcase
      endfunction

      // backward time counts as no gap
      function data_type elapsed(data_type t0, data_type t1);
         return (t1 >= t0) ? t1 - t0 : '0;
      endfunction

      function data_type misses_for_gap(data_type gap);
         data_type reduced;
         if (gap < tolerance) return '0;
         reduced = gap - tolerance;
         if (min_gap != '0 && reduced < min_gap) return '0;
         if (max_gap != ALL_ONES && reduced > max_gap) return '0;
         if (interval == '0) return '0;
         if (reduced <= interval) return '0;
         return reduced / interval;
      endfunction

      function void note_item(mode_type mode, data_type ts, logic upd_valid);
         gap_event_type      ev;
         logic [DATA_W:0]    sum;
         ev.gap    = '0;
         ev.misses = '0;
         case (mode)
            MODE_START: begin
               ev.kind    = EV_ENTERED;
               last_time  = ts;
               valid_seen = 1'b0;
            end
            MODE_UPDATE: begin
               if (!upd_valid) begin
                  ev.kind = EV_INVALID;
               end else begin
                  ev.kind    = valid_seen ? EV_VALID : EV_FIRST;
                  ev.gap     = elapsed(last_time, ts);
                  ev.misses  = misses_for_gap(ev.gap);
                  last_time  = ts;
                  valid_seen = 1'b1;
               end
            end
            MODE_END: begin
               ev.gap = elapsed(last_time, ts);
               if (valid_seen) begin
                  ev.kind   = EV_END_VALID;
                  ev.misses = misses_for_gap(ev.gap);
               end else begin
                  ev.kind = EV_EMPTY_END;
               end
               valid_seen = 1'b0;
            end
            default: return;
         endcase
         // saturating running total
         sum           = {1'b0, running_total} + {1'b0, ev.misses};
         running_total = sum[DATA_W] ? ALL_ONES : sum[DATA_W-1:0];
         ev.total      = running_total;
         expected_events.insert(expected_events.size(), ev);
      endfunction

      function void compare_field(string name, data_type exp_val, data_type act_val);
         if (exp_val !== act_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            errors++;
         end
      endfunction

      function void check_event(logic [2:0] kind, logic [95:0] data);
         gap_event_type ev;
         if (expected_events.size() == 0) begin
            $error("unexpected result transaction: event_kind %0d", kind);
            errors++;
            return;
         end
         ev = expected_events.pop_front();
         compare_field("event_kind", data_type'(ev.kind), data_type'(kind));
         compare_field("gap_ms", ev.gap, data[31:0]);
         compare_field("misses", ev.misses, data[63:32]);
         compare_field("miss_sum", ev.total, data[95:64]);
      endfunction

      function int pending();
         return expected_events.size();
      endfunction
   endclass

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic [2:0]  req_tuser  = '0;   // mode [1:0], update_valid [2]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;         // gap_ms [31:0], misses [63:32], miss_sum [95:64]
   logic [2:0]  rsp_tuser;         // event_kind
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_addr   = '0;
   logic [31:0] csr_wdata  = '0;

   int sender_idle_pct = 0;
   int stall_pct       = 0;
   int items_sent      = 0;

   gap_miss_scoreboard_type ledger = new();

   update_gap_miss_counter_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hang guard
   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

   // random receiver back-pressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // result transaction check
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) ledger.check_event(rsp_tuser, rsp_tdata);
   end

   function automatic int sender_gap();
      int n;
      n = 0;
      while (n < 40 && $urandom_range(99) < sender_idle_pct) n++;
      return n;
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_item(mode_type mode, data_type ts, logic upd_valid);
      int gap_cycles;
      gap_cycles = sender_gap();
      if (gap_cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap_cycles) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ts;
      req_tuser  <= {upd_valid, mode};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ledger.note_item(mode, ts, upd_valid);
      if (mode != MODE_NONE) items_sent++;
      @(negedge clock);
   endtask

   // let every expected result arrive, then cover an in-flight ignored item
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (ledger.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(csr_type idx, data_type value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      ledger.set_register(idx, value);
      @(negedge clock);
   endtask

   task automatic configure(data_type ivl, data_type tol, data_type mn, data_type mx);
      write_csr(CSR_INTERVAL, ivl);
      write_csr(CSR_TOLERANCE, tol);
      write_csr(CSR_MIN_GAP, mn);
      write_csr(CSR_MAX_GAP, mx);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // time advance between items: often near interval multiples, sometimes small, some wild jumps
   function automatic data_type step_for(data_type ivl);
      data_type          unit;
      longint unsigned   s;
      unit = (ivl == '0) ? 32'd1000 : ivl;
      case ($urandom_range(4))
         0: s = longint'(unit) * $urandom_range(1, 6) + $urandom_range(0, 50);
         1: s = longint'(unit) * $urandom_range(1, 6) - $urandom_range(0, 50);
         2: s = $urandom_range(0, unit);
         3: s = $urandom();
         default: s = $urandom_range(0, 20);
      endcase
      return s[31:0];
   endfunction

   // well-formed period with random content, occasionally missing its start or end
   task automatic send_period(data_type ivl);
      data_type t;
      int       n;
      t = $urandom();
      if ($urandom_range(9) != 0) send_item(MODE_START, t, 1'($urandom_range(1)));
      n = $urandom_range(8);
      repeat (n) begin
         t = t + step_for(ivl);
         send_item(MODE_UPDATE, t, $urandom_range(9) != 0);
      end
      if ($urandom_range(9) != 0) begin
         t = t + step_for(ivl);
         send_item(MODE_END, t, 1'($urandom_range(1)));
      end
   endtask

   initial begin
      data_type ivl, tol, mn, mx;
      int       phase_start;

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset settings, interval 1000
      send_item(MODE_START, 32'd0, 1'b0);
      send_item(MODE_UPDATE, 32'd100, 1'b0);         // invalid update
      send_item(MODE_UPDATE, 32'd500, 1'b1);         // first valid, below interval
      send_item(MODE_UPDATE, 32'd3700, 1'b1);        // three misses
      send_item(MODE_UPDATE, 32'd4700, 1'b1);        // gap equal to interval
      send_item(MODE_END, 32'd9000, 1'b1);           // end after valid
      send_item(MODE_END, 32'd9500, 1'b0);           // empty end, last time kept
      send_item(MODE_UPDATE, 32'd12000, 1'b1);       // no period start
      send_item(MODE_UPDATE, 32'd100, 1'b1);         // time going backward
      send_item(MODE_NONE, 32'hFFFF_FFFF, 1'b1);     // ignored
      send_item(MODE_START, 32'hFFFF_FFFF, 1'b1);
      send_item(MODE_UPDATE, 32'd0, 1'b1);           // backward across full range
      send_item(MODE_END, 32'hFFFF_FFFF, 1'b0);      // maximal gap
      wait_idle();

      // tolerance above gap, then reduced gap
      configure(32'd1000, 32'd500, 32'd0, ALL_ONES);
      send_item(MODE_START, 32'd0, 1'b0);
      send_item(MODE_UPDATE, 32'd400, 1'b1);
      send_item(MODE_UPDATE, 32'd2900, 1'b1);
      wait_idle();

      // min and max window
      configure(32'd1000, 32'd0, 32'd3000, 32'd5000);
      send_item(MODE_START, 32'd0, 1'b0);
      send_item(MODE_UPDATE, 32'd2500, 1'b1);        // below min
      send_item(MODE_UPDATE, 32'd8500, 1'b1);        // above max
      send_item(MODE_END, 32'd13000, 1'b1);          // inside window
      wait_idle();

      // zero interval register
      configure(32'd0, 32'd0, 32'd0, ALL_ONES);
      send_item(MODE_START, 32'd0, 1'b0);
      send_item(MODE_UPDATE, 32'd5000, 1'b1);
      wait_idle();

      // random phases over settings and idle patterns
      for (int p = 0; p < 12; p++) begin
         case (p % 4)
            0: begin sender_idle_pct = 0;  stall_pct = 0;  end
            1: begin sender_idle_pct = 81; stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  stall_pct = 81; end
            default: begin sender_idle_pct = 23; stall_pct = 23; end
         endcase
         ivl = $urandom_range(1, 5000);
         tol = $urandom_range(0, ivl);
         mn  = $urandom_range(1) ? 32'd0 : $urandom_range(0, 3 * ivl);
         mx  = $urandom_range(1) ? ALL_ONES : mn + $urandom_range(ivl, 8 * ivl);
         case (p)
            0: begin ivl = INTERVAL_RESET; tol = '0; mn = '0; mx = ALL_ONES; end
            1: begin ivl = 32'd1; tol = '0; mn = '0; mx = ALL_ONES; end   // saturates total
            2: ivl = '0;
            3: begin ivl = ALL_ONES; tol = $urandom(); end
            4: begin ivl = 32'd10; tol = 32'd5; mn = 32'd30; mx = 32'd200; end
            5: tol = ALL_ONES;
            6: mn = ALL_ONES;
            7: mx = '0;
            default: ;
         endcase
         configure(ivl, tol, mn, mx);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(4) == 0)
               send_item(mode_type'($urandom_range(3)), $urandom(), 1'($urandom_range(1)));
            else
               send_period(ivl);
         end
         wait_idle();
      end

      if (ledger.errors == 0 && ledger.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
